// ===== rtl/linear_least_squares_fit_macros.svh =====
// Assertion macros for the least-squares fit block.
// Included by the RTL files that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef LINEAR_LEAST_SQUARES_FIT_MACROS_SVH
`define LINEAR_LEAST_SQUARES_FIT_MACROS_SVH
`ifndef SYNTHESIS
`define LLSF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LLSF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LLSF_ASSERT_IMP(lbl, ante, cons, msg)
`define LLSF_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/llsf_pkg.sv =====
// Shared types and status codes of the least-squares fit block.
// Has no dependencies; the top level refers to it by scoped names.
package llsf_pkg;

    typedef struct packed {
        logic signed [15:0] x_sample;
        logic signed [15:0] y_sample;
        logic               last_point;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] intercept;
        logic signed [31:0] slope;
        logic [15:0]        correlation;
        logic [1:0]         status;
    } result_t;

    localparam logic [1:0] STATUS_OK  = 2'd0;
    localparam logic [1:0] STATUS_DET = 2'd1;
    localparam logic [1:0] STATUS_VAR = 2'd2;

endpackage

// ===== rtl/linear_least_squares_fit.sv =====
// Top level of the least-squares straight-line fit with its sample store and solver.
// Depends on llsf_pkg and on linear_least_squares_fit_macros.svh.
//
// Samples are taken one per cycle while busy is low; while the point store has room, each is
// written to it and added into the running sums. A beat with last_point set starts the fit,
// and busy stays high until the result beat, which is shown for one cycle with done high and
// cannot be stalled. The fit runs on a shared shift-add multiplier (a load step, a shift-add
// step per bit of the second operand up to its highest set bit, and a closing step), a
// restoring divider (a load step and a step for each of the 64 quotient bits, cut short when
// the quotient saturates) and a 16-step square root. At the default depth, the eight products
// of the sums use at most 35 operand bits. The residual pass walks the store once, with a
// read state, an alignment state, a load state and the multiplier steps for each stored
// point. A zero determinant ends the fit after the second product.
`include "linear_least_squares_fit_macros.svh"

module linear_least_squares_fit #(
    parameter int MAX_POINTS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  llsf_pkg::sample_t sample,
    output logic             done,
    output llsf_pkg::result_t result
);

    localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int SXW = 16 + CW;
    localparam int SQW = 32 + CW;
    localparam int EW  = 50;

    typedef enum logic [9:0] {
        ST_LOAD = 10'b0000000001,
        ST_MLD  = 10'b0000000010,
        ST_MUL  = 10'b0000000100,
        ST_NUM  = 10'b0000001000,
        ST_DIV  = 10'b0000010000,
        ST_RD   = 10'b0000100000,
        ST_AX   = 10'b0001000000,
        ST_ERR  = 10'b0010000000,
        ST_SQRT = 10'b0100000000,
        ST_DONE = 10'b1000000000
    } state_t;

    typedef enum logic [3:0] {
        OP_NSXX, OP_SXSX, OP_SYSXX, OP_SXSXY, OP_NSXY, OP_SXSY,
        OP_EE, OP_NSYY, OP_SYSY, OP_DVA0, OP_DVA1, OP_DVR
    } op_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    logic [CW-1:0]         count_reg, count_next;
    logic signed [SXW-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic signed [SQW-1:0] sxx_reg, sxx_next, sxy_reg, sxy_next;

    logic signed [SQW:0]   syy_reg, syy_next;
    logic signed [127:0]   acc_reg, acc_next, t_reg, t_next;
    logic [63:0]           det_reg, det_next;
    logic [127:0]          mul_a_reg, mul_a_next, mul_p_reg, mul_p_next;
    logic [63:0]           mul_b_reg, mul_b_next;
    logic                  mul_neg_reg, mul_neg_next;
    logic [63:0]           div_rem_reg, div_rem_next, div_lo_reg, div_lo_next;
    logic [63:0]           div_q_reg, div_q_next, div_d_reg, div_d_next;
    logic [63:0]           div_lim_reg, div_lim_next;
    logic                  div_neg_reg, div_neg_next, div_sat_reg, div_sat_next;
    logic [5:0]            div_cnt_reg, div_cnt_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic signed [47:0]    ax_reg, ax_next;
    logic signed [15:0]    y_reg, y_next;
    logic [30:0]           sq_v_reg, sq_v_next, sq_res_reg, sq_res_next;
    logic [30:0]           sq_bit_reg, sq_bit_next;
    logic signed [31:0]    a0_reg, a0_next, a1_reg, a1_next;
    logic [15:0]           corr_reg, corr_next;
    logic [1:0]            status_reg, status_next;

    logic [31:0]   mem [MAX_POINTS];
    logic [31:0]   rd_data;
    logic          mem_we, rd_en;
    logic [AW-1:0] wr_addr;

    logic signed [63:0]  op_a, op_b;
    logic signed [127:0] prod, diff, num_sel;
    logic [127:0]        num_mag;
    logic [64:0]         div_sh;
    logic [63:0]         div_r;
    logic                div_take;
    logic [63:0]         div_qn, div_qf;
    logic [31:0]         div_res;
    logic signed [EW-1:0] e_val;
    logic signed [63:0]  en_val;
    logic [31:0]         sq_sum;
    logic signed [31:0]  xx_prod, xy_prod, yy_prod;
    logic                accept;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_LOAD);
    assign done   = (state_reg == ST_DONE);
    assign result = '{intercept: a0_reg, slope: a1_reg, correlation: corr_reg,
                      status: status_reg};

    assign xx_prod = sample.x_sample * sample.x_sample;
    assign xy_prod = sample.x_sample * sample.y_sample;
    assign yy_prod = $signed(rd_data[15:0]) * $signed(rd_data[15:0]);
    assign mem_we  = accept && (count_reg < CW'(MAX_POINTS));
    assign wr_addr = count_reg[AW-1:0];
    assign rd_en   = (state_reg == ST_RD);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= {sample.x_sample, sample.y_sample};
        end
        if (rd_en)
        begin
            rd_data <= mem[idx_reg[AW-1:0]];
        end
    end

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (op_reg)
            OP_NSXX:  begin op_a = 64'(count_reg); op_b = 64'(sxx_reg); end
            OP_SXSX:  begin op_a = 64'(sx_reg);    op_b = 64'(sx_reg);  end
            OP_SYSXX: begin op_a = 64'(sy_reg);    op_b = 64'(sxx_reg); end
            OP_SXSXY: begin op_a = 64'(sx_reg);    op_b = 64'(sxy_reg); end
            OP_NSXY:  begin op_a = 64'(count_reg); op_b = 64'(sxy_reg); end
            OP_SXSY:  begin op_a = 64'(sx_reg);    op_b = 64'(sy_reg);  end
            OP_NSYY:  begin op_a = 64'(count_reg); op_b = 64'(syy_reg); end
            OP_SYSY:  begin op_a = 64'(sy_reg);    op_b = 64'(sy_reg);  end
            default:  begin op_a = '0;             op_b = '0;           end
        endcase
    end

    assign prod    = mul_neg_reg ? (~mul_p_reg + 128'd1) : mul_p_reg;
    assign diff    = acc_reg - prod;
    assign num_sel = (op_reg == OP_SXSXY) ? (diff <<< 8) : (diff <<< 16);
    assign num_mag = acc_reg[127] ? 128'(-acc_reg) : 128'(acc_reg);

    assign div_sh   = {div_rem_reg, div_lo_reg[63]};
    assign div_r    = div_sh[63:0];
    assign div_take = div_sh[64] || (div_r >= div_d_reg);
    assign div_qn   = {div_q_reg[62:0], div_take};
    assign div_qf   = div_sat_reg ? div_lim_reg :
                      ((div_qn > div_lim_reg) ? div_lim_reg : div_qn);
    assign div_res  = div_neg_reg ? (32'd0 - div_qf[31:0]) : div_qf[31:0];

    assign e_val  = (EW'(y_reg) <<< 16) - (EW'(a0_reg) <<< 8) - EW'(ax_reg);
    assign en_val = 64'(e_val) * $signed({1'b0, count_reg});
    assign sq_sum = {1'b0, sq_res_reg} + {1'b0, sq_bit_reg};

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        count_next   = count_reg;
        sx_next      = sx_reg;
        sy_next      = sy_reg;
        sxx_next     = sxx_reg;
        sxy_next     = sxy_reg;
        syy_next     = syy_reg;
        acc_next     = acc_reg;
        t_next       = t_reg;
        det_next     = det_reg;
        mul_a_next   = mul_a_reg;
        mul_b_next   = mul_b_reg;
        mul_p_next   = mul_p_reg;
        mul_neg_next = mul_neg_reg;
        div_rem_next = div_rem_reg;
        div_lo_next  = div_lo_reg;
        div_q_next   = div_q_reg;
        div_d_next   = div_d_reg;
        div_lim_next = div_lim_reg;
        div_neg_next = div_neg_reg;
        div_sat_next = div_sat_reg;
        div_cnt_next = div_cnt_reg;
        idx_next     = idx_reg;
        ax_next      = ax_reg;
        y_next       = y_reg;
        sq_v_next    = sq_v_reg;
        sq_res_next  = sq_res_reg;
        sq_bit_next  = sq_bit_reg;
        a0_next      = a0_reg;
        a1_next      = a1_reg;
        corr_next    = corr_reg;
        status_next  = status_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (mem_we)
                    begin
                        count_next = count_reg + CW'(1);
                        sx_next    = sx_reg + SXW'(sample.x_sample);
                        sy_next    = sy_reg + SXW'(sample.y_sample);
                        sxx_next   = sxx_reg + SQW'(xx_prod);
                        sxy_next   = sxy_reg + SQW'(xy_prod);
                    end
                    if (sample.last_point)
                    begin
                        op_next    = OP_NSXX;
                        state_next = ST_MLD;
                    end
                end
            end
            ST_MLD:
            begin
                mul_a_next   = 128'(mag64(op_a));
                mul_b_next   = mag64(op_b);
                mul_neg_next = op_a[63] ^ op_b[63];
                mul_p_next   = '0;
                state_next   = ST_MUL;
            end
            ST_MUL:
            begin
                if (mul_b_reg != 64'd0)
                begin
                    if (mul_b_reg[0])
                    begin
                        mul_p_next = mul_p_reg + mul_a_reg;
                    end
                    mul_a_next = mul_a_reg << 1;
                    mul_b_next = mul_b_reg >> 1;
                end
                else
                begin
                    case (op_reg)
                        OP_NSXX, OP_SYSXX, OP_NSXY, OP_NSYY:
                        begin
                            acc_next   = prod;
                            op_next    = op_t'(op_reg + 4'd1);
                            state_next = ST_MLD;
                        end
                        OP_SXSX:
                        begin
                            if (diff[127] || (diff == 128'd0))
                            begin
                                a0_next     = '0;
                                a1_next     = '0;
                                corr_next   = '0;
                                status_next = llsf_pkg::STATUS_DET;
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                det_next   = diff[63:0];
                                op_next    = OP_SYSXX;
                                state_next = ST_MLD;
                            end
                        end
                        OP_SXSXY, OP_SXSY:
                        begin
                            acc_next   = num_sel;
                            div_d_next = det_reg;
                            state_next = ST_NUM;
                        end
                        OP_EE:
                        begin
                            t_next     = t_reg + prod;
                            idx_next   = idx_reg + CW'(1);
                            if (idx_reg + CW'(1) == count_reg)
                            begin
                                op_next    = OP_NSYY;
                                state_next = ST_MLD;
                            end
                            else
                            begin
                                state_next = ST_RD;
                            end
                        end
                        OP_SYSY:
                        begin
                            if (diff[127] || (diff == 128'd0))
                            begin
                                corr_next   = '0;
                                status_next = llsf_pkg::STATUS_VAR;
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                acc_next   = t_reg;
                                div_d_next = {diff[61:0], 2'b00};
                                state_next = ST_NUM;
                            end
                        end
                        default:
                        begin
                            state_next = ST_LOAD;
                        end
                    endcase
                end
            end
            ST_NUM:
            begin
                div_rem_next = num_mag[127:64];
                div_lo_next  = num_mag[63:0];
                div_q_next   = '0;
                div_cnt_next = '0;
                div_neg_next = acc_reg[127];
                div_sat_next = num_mag[127:64] >= div_d_reg;
                state_next   = ST_DIV;
                case (op_reg)
                    OP_SXSXY:
                    begin
                        div_lim_next = acc_reg[127] ? 64'h8000_0000 : 64'h7FFF_FFFF;
                        op_next      = OP_DVA0;
                    end
                    OP_SXSY:
                    begin
                        div_lim_next = acc_reg[127] ? 64'h8000_0000 : 64'h7FFF_FFFF;
                        op_next      = OP_DVA1;
                    end
                    default:
                    begin
                        div_lim_next = 64'd1 << 30;
                        op_next      = OP_DVR;
                    end
                endcase
            end
            ST_DIV:
            begin
                div_rem_next = div_take ? (div_r - div_d_reg) : div_r;
                div_lo_next  = div_lo_reg << 1;
                div_q_next   = div_qn;
                div_cnt_next = div_cnt_reg + 6'd1;
                if (div_sat_reg || (div_cnt_reg == 6'd63))
                begin
                    case (op_reg)
                        OP_DVA0:
                        begin
                            a0_next    = div_res;
                            op_next    = OP_NSXY;
                            state_next = ST_MLD;
                        end
                        OP_DVA1:
                        begin
                            a1_next    = div_res;
                            idx_next   = '0;
                            t_next     = '0;
                            syy_next   = '0;
                            state_next = ST_RD;
                        end
                        default:
                        begin
                            sq_v_next   = 31'((64'd1 << 30) - div_qf);
                            sq_res_next = '0;
                            sq_bit_next = 31'd1 << 30;
                            state_next  = ST_SQRT;
                        end
                    endcase
                end
            end
            ST_RD:
            begin
                state_next = ST_AX;
            end
            ST_AX:
            begin
                ax_next    = a1_reg * $signed(rd_data[31:16]);
                y_next     = $signed(rd_data[15:0]);
                syy_next   = syy_reg + (SQW + 1)'(yy_prod);
                state_next = ST_ERR;
            end
            ST_ERR:
            begin
                mul_a_next   = 128'(mag64(en_val));
                mul_b_next   = mag64(64'(e_val));
                mul_neg_next = en_val[63] ^ e_val[EW-1];
                mul_p_next   = '0;
                op_next      = OP_EE;
                state_next   = ST_MUL;
            end
            ST_SQRT:
            begin
                if ({1'b0, sq_v_reg} >= sq_sum)
                begin
                    sq_v_next   = sq_v_reg - sq_sum[30:0];
                    sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_res_next = sq_res_reg >> 1;
                end
                sq_bit_next = sq_bit_reg >> 2;
                if (sq_bit_reg == 31'd1)
                begin
                    corr_next   = sq_res_next[15:0];
                    status_next = llsf_pkg::STATUS_OK;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE:
            begin
                count_next = '0;
                sx_next    = '0;
                sy_next    = '0;
                sxx_next   = '0;
                sxy_next   = '0;
                state_next = ST_LOAD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            op_reg    <= OP_NSXX;
            count_reg <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            sxx_reg   <= '0;
            sxy_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            count_reg <= count_next;
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            sxx_reg   <= sxx_next;
            sxy_reg   <= sxy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        syy_reg     <= syy_next;
        acc_reg     <= acc_next;
        t_reg       <= t_next;
        det_reg     <= det_next;
        mul_a_reg   <= mul_a_next;
        mul_b_reg   <= mul_b_next;
        mul_p_reg   <= mul_p_next;
        mul_neg_reg <= mul_neg_next;
        div_rem_reg <= div_rem_next;
        div_lo_reg  <= div_lo_next;
        div_q_reg   <= div_q_next;
        div_d_reg   <= div_d_next;
        div_lim_reg <= div_lim_next;
        div_neg_reg <= div_neg_next;
        div_sat_reg <= div_sat_next;
        div_cnt_reg <= div_cnt_next;
        idx_reg     <= idx_next;
        ax_reg      <= ax_next;
        y_reg       <= y_next;
        sq_v_reg    <= sq_v_next;
        sq_res_reg  <= sq_res_next;
        sq_bit_reg  <= sq_bit_next;
        a0_reg      <= a0_next;
        a1_reg      <= a1_next;
        corr_reg    <= corr_next;
        status_reg  <= status_next;
    end

    `LLSF_ASSERT_IMP(a_done_busy, done, busy, "result beat outside the fit")
    `LLSF_ASSERT_NXT(a_done_once, done, !done, "result beat held longer than one cycle")
    `LLSF_ASSERT_NXT(a_last_starts, start && !busy && sample.last_point, busy, "fit did not start")
    `LLSF_ASSERT_IMP(a_det_zero, done && (result.status == llsf_pkg::STATUS_DET), (result.intercept == 32'sd0) && (result.slope == 32'sd0), "coefficients nonzero on singular fit")
    `LLSF_ASSERT_NXT(a_done_clears, done, count_reg == '0, "point count not cleared after fit")

endmodule
